// ===== rtl/lcdnw_pkg.sv =====
// Shared types and constants for the character LCD nibble writer.
`timescale 1ns / 1ps
package lcdnw_pkg;

  // Display geometry
  localparam int LINE_WIDTH = 16;
  localparam int COL_W      = 6;
  localparam logic [COL_W-1:0] COL_MAX = '1;

  // Deepest nibble sequence one item can cause (init)
  localparam int MAX_NIB = 14;
  localparam int CNT_W   = $clog2(MAX_NIB + 1);

  // Opcodes
  localparam logic [2:0] OP_TEXT  = 3'd0;
  localparam logic [2:0] OP_RAW   = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_HOME  = 3'd3;
  localparam logic [2:0] OP_SETPOS = 3'd4;
  localparam logic [2:0] OP_GLYPH = 3'd5;
  localparam logic [2:0] OP_INIT  = 3'd6;

  // Character codes with special meaning in text mode
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  // Controller instructions
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  // Register select codes
  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  // Power-up sequence: three wake nibbles, 4-bit switch, then
  // function set 0x28, display on 0x0E, clear 0x01, entry mode 0x06, DDRAM address 0x80
  localparam logic [3:0] INIT_NIB [MAX_NIB] = '{
    4'h3, 4'h3, 4'h3, 4'h2,
    4'h2, 4'h8, 4'h0, 4'hE, 4'h0, 4'h1, 4'h0, 4'h6, 4'h8, 4'h0
  };

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] payload;
    logic       target_row;
    logic [7:0] target_col;
    logic [2:0] glyph_slot;
    logic [2:0] glyph_line;
  } lcdnw_in_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic       last;
  } lcdnw_out_t;

endpackage

// ===== rtl/char_lcd_nibble_writer_top.sv =====
// Character LCD 4-bit front end: turns operations into tagged display nibbles.
`timescale 1ns / 1ps
// Each accepted beat is one display operation (text, raw command, clear,
// home, set position, glyph row, init). In the cycle it is accepted the
// operation is decoded against the current cursor, the cursor is updated,
// and the full nibble sequence it causes (0 to 14 nibbles, high nibble of
// each byte first) is loaded into a sequence register. From there one
// nibble per cycle, while the output register is free, moves into it. A
// text character gives 2 or 4 nibbles, a command 2, a glyph row 4 or 6,
// init 14; an item with no nibbles (NUL, ignored set position, unused
// opcode) loads an empty sequence. Unless the consumer stalls, the output
// beat rate of one nibble per cycle sets the throughput. The next
// item is accepted in the same cycle that the last nibble of the current
// one moves to the output register, so back-to-back items leave no gap.
// Once that last nibble sits in the output register, a new item is taken
// even while the consumer stalls it; the new sequence then holds until the
// output register frees up, and the input is held off meanwhile. The final
// nibble of each item carries last. The cursor column saturates at 63; the
// row is 0 or 1.
module char_lcd_nibble_writer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcdnw_pkg::lcdnw_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lcdnw_pkg::lcdnw_out_t out_data
);
  import lcdnw_pkg::*;

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
  } nib_t;

  localparam logic [COL_W-1:0] LW_COL  = COL_W'(LINE_WIDTH);
  localparam logic [7:0]       LW_BYTE = 8'(LINE_WIDTH);

  // Sequence register and its fill count
  nib_t             seq_r   [MAX_NIB];
  nib_t             seq_nxt [MAX_NIB];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Cursor
  logic [COL_W-1:0] cursor_col_r, cursor_col_nxt;
  logic             cursor_row_r, cursor_row_nxt;

  // Output register
  logic       out_valid_r;
  lcdnw_out_t out_data_r;

  // Decode results
  logic [7:0]       byte_v [3];
  logic             rs_v   [3];
  logic [1:0]       nbyte;
  logic             init_sel;
  nib_t             seq_new [MAX_NIB];
  logic [CNT_W-1:0] n_new;

  logic             move;
  logic             accept;
  logic [COL_W-1:0] col_inc;

  // Advance the head nibble whenever the output register is free
  assign move     = (cnt_r != '0) && (!out_valid_r || out_ready);
  assign in_ready = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && move);
  assign accept   = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign col_inc = (cursor_col_r != COL_MAX) ? cursor_col_r + COL_W'(1) : cursor_col_r;

  // Decode one operation into up to three bytes (or the init table)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      byte_v[i] = '0;
      rs_v[i]   = RS_INSTR;
    end
    nbyte          = 2'd0;
    init_sel       = 1'b0;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;

    case (in_data.opcode)
      OP_TEXT: begin
        if (in_data.payload == CHAR_NUL) begin
          nbyte = 2'd0;
        end else if (in_data.payload == CHAR_LF) begin
          // Drop to the bottom row, same column, if the column is on screen
          if (cursor_col_r < LW_COL) begin
            byte_v[0]      = CMD_SET_DDRAM | {2'b01, cursor_col_r};
            nbyte          = 2'd1;
            cursor_row_nxt = 1'b1;
          end
        end else if (in_data.payload == CHAR_CR) begin
          byte_v[0]      = CMD_SET_DDRAM | {1'b0, cursor_row_r, {COL_W{1'b0}}};
          nbyte          = 2'd1;
          cursor_col_nxt = '0;
        end else begin
          byte_v[0]      = in_data.payload;
          rs_v[0]        = RS_DATA;
          nbyte          = 2'd1;
          cursor_col_nxt = col_inc;
          // Wrap from the end of the top row to the start of the bottom row
          if ((col_inc == LW_COL) && !cursor_row_r) begin
            byte_v[1]      = CMD_SET_DDRAM | {2'b01, {COL_W{1'b0}}};
            nbyte          = 2'd2;
            cursor_col_nxt = '0;
            cursor_row_nxt = 1'b1;
          end
        end
      end
      OP_RAW: begin
        byte_v[0] = in_data.payload;
        nbyte     = 2'd1;
      end
      OP_CLEAR, OP_HOME: begin
        byte_v[0]      = (in_data.opcode == OP_CLEAR) ? CMD_CLEAR : CMD_HOME;
        nbyte          = 2'd1;
        cursor_col_nxt = '0;
        cursor_row_nxt = 1'b0;
      end
      OP_SETPOS: begin
        if (in_data.target_col < LW_BYTE) begin
          byte_v[0] = CMD_SET_DDRAM |
                      {1'b0, in_data.target_row, in_data.target_col[COL_W-1:0]};
          nbyte          = 2'd1;
          cursor_col_nxt = in_data.target_col[COL_W-1:0];
          cursor_row_nxt = in_data.target_row;
        end
      end
      OP_GLYPH: begin
        byte_v[0] = CMD_SET_CGRAM | {2'b00, in_data.glyph_slot, in_data.glyph_line};
        byte_v[1] = in_data.payload;
        rs_v[1]   = RS_DATA;
        nbyte     = 2'd2;
        // Restore the display address after the last pixel row
        if ((in_data.glyph_line == 3'd7) && (cursor_col_r < LW_COL)) begin
          byte_v[2] = CMD_SET_DDRAM | {1'b0, cursor_row_r, cursor_col_r};
          nbyte     = 2'd3;
        end
      end
      OP_INIT: begin
        init_sel       = 1'b1;
        cursor_col_nxt = '0;
        cursor_row_nxt = 1'b0;
      end
      default: begin
        nbyte = 2'd0;
      end
    endcase
  end

  // Split bytes into high/low nibbles, or take the init table
  always_comb begin
    for (int i = 0; i < MAX_NIB; i++) begin
      seq_new[i] = '{nibble: INIT_NIB[i], rs: RS_INSTR};
    end
    if (!init_sel) begin
      for (int i = 0; i < 6; i++) begin
        seq_new[i].nibble = (i % 2 == 0) ? byte_v[i/2][7:4] : byte_v[i/2][3:0];
        seq_new[i].rs     = rs_v[i/2];
      end
    end
    n_new = init_sel ? CNT_W'(MAX_NIB) : CNT_W'({nbyte, 1'b0});
  end

  // Load a new sequence on accept, else shift out the head on move
  always_comb begin
    for (int i = 0; i < MAX_NIB; i++) begin
      seq_nxt[i] = seq_r[i];
    end
    cnt_nxt = cnt_r;
    if (accept) begin
      for (int i = 0; i < MAX_NIB; i++) begin
        seq_nxt[i] = seq_new[i];
      end
      cnt_nxt = n_new;
    end else if (move) begin
      for (int i = 0; i < MAX_NIB - 1; i++) begin
        seq_nxt[i] = seq_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_NIB; i++) begin
      seq_r[i] <= seq_nxt[i];
    end
    if (move) begin
      out_data_r.nibble     <= seq_r[0].nibble;
      out_data_r.reg_select <= seq_r[0].rs;
      out_data_r.last       <= (cnt_r == CNT_W'(1));
    end
    if (!rst_n) begin
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      cursor_col_r <= '0;
      cursor_row_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        cursor_col_r <= cursor_col_nxt;
        cursor_row_r <= cursor_row_nxt;
      end
    end
  end

  // Init loads the full sequence and homes the cursor
  a_init_load: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.opcode == OP_INIT)) |=>
      ((cnt_r == CNT_W'(MAX_NIB)) && (cursor_col_r == '0) && !cursor_row_r))
    else $error("init did not load sequence or home cursor");

  // Fill count never exceeds the sequence depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_NIB))
    else $error("sequence count out of range");

  // An idle block takes input
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == '0) && !out_valid_r) |-> in_ready)
    else $error("idle block not ready");

  // Newline with an on-screen column lands on the bottom row
  a_newline_row: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.opcode == OP_TEXT) && (in_data.payload == CHAR_LF) &&
     (cursor_col_r < LW_COL)) |=> cursor_row_r)
    else $error("newline did not move to bottom row");

endmodule

// ===== test/lcdnw_checker.sv =====
// Nibble predictor and scoreboard for the character LCD nibble writer.
`timescale 1ns / 1ps
module lcdnw_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  lcdnw_pkg::lcdnw_in_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  lcdnw_pkg::lcdnw_out_t out_data,
  output int                    mismatch_count,
  output int                    nibbles_owed
);
  import lcdnw_pkg::*;

  localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0E;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] DDRAM_ROW1      = 8'd64;
  localparam logic [3:0] NIB_WAKE        = 4'h3;
  localparam logic [3:0] NIB_4BIT        = 4'h2;
  localparam logic [2:0] GLYPH_LAST_LINE = 3'd7;

  lcdnw_out_t       pending_nibbles[$];
  lcdnw_out_t       op_nibbles[$];
  lcdnw_out_t       want;
  logic [COL_W-1:0] col_now = '0;
  logic             row_now = 1'b0;
  int               errors = 0;

  task automatic put_nibble(input logic [3:0] nib, input logic rs);
    lcdnw_out_t beat;
    beat.nibble     = nib;
    beat.reg_select = rs;
    beat.last       = 1'b0;
    op_nibbles.push_back(beat);
  endtask

  task automatic put_byte(input logic [7:0] b, input logic rs);
    put_nibble(b[7:4], rs);
    put_nibble(b[3:0], rs);
  endtask

  // Address the display and load the cursor; drop the move off the line end.
  task automatic move_cursor(input logic row, input logic [7:0] col);
    if (col < LINE_WIDTH) begin
      put_byte(CMD_SET_DDRAM + (row ? DDRAM_ROW1 : 8'd0) + col, RS_INSTR);
      col_now = col[COL_W-1:0];
      row_now = row;
    end
  endtask

  task automatic decode_operation(input lcdnw_in_t op);
    op_nibbles.delete();
    case (op.opcode)
      OP_TEXT: begin
        // NUL falls through every branch and sends nothing
        if (op.payload == CHAR_LF) begin
          move_cursor(1'b1, 8'(col_now));
        end else if (op.payload == CHAR_CR) begin
          col_now = '0;
          move_cursor(row_now, 8'd0);
        end else if (op.payload != CHAR_NUL) begin
          put_byte(op.payload, RS_DATA);
          if (col_now != COL_MAX) col_now = col_now + 1'b1;
          if (col_now == LINE_WIDTH && !row_now) move_cursor(1'b1, 8'd0);
        end
      end
      OP_RAW: put_byte(op.payload, RS_INSTR);
      OP_CLEAR, OP_HOME: begin
        put_byte((op.opcode == OP_CLEAR) ? CMD_CLEAR : CMD_HOME, RS_INSTR);
        col_now = '0;
        row_now = 1'b0;
      end
      OP_SETPOS: move_cursor(op.target_row, op.target_col);
      OP_GLYPH: begin
        put_byte(CMD_SET_CGRAM | {2'b00, op.glyph_slot, op.glyph_line}, RS_INSTR);
        put_byte(op.payload, RS_DATA);
        if (op.glyph_line == GLYPH_LAST_LINE) move_cursor(row_now, 8'(col_now));
      end
      OP_INIT: begin
        put_nibble(NIB_WAKE, RS_INSTR);
        put_nibble(NIB_WAKE, RS_INSTR);
        put_nibble(NIB_WAKE, RS_INSTR);
        put_nibble(NIB_4BIT, RS_INSTR);
        put_byte(CMD_FUNC_SET, RS_INSTR);
        put_byte(CMD_DISPLAY_ON, RS_INSTR);
        put_byte(CMD_CLEAR, RS_INSTR);
        put_byte(CMD_ENTRY_MODE, RS_INSTR);
        put_byte(CMD_SET_DDRAM, RS_INSTR);
        col_now = '0;
        row_now = 1'b0;
      end
      default: ;
    endcase
    if (op_nibbles.size() > 0) op_nibbles[op_nibbles.size() - 1].last = 1'b1;
    foreach (op_nibbles[i]) pending_nibbles.push_back(op_nibbles[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      col_now = '0;
      row_now = 1'b0;
      pending_nibbles.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_nibbles.size() == 0) begin
          $error("nibble beat with none owed: nibble %h reg_select %b last %b",
                 out_data.nibble, out_data.reg_select, out_data.last);
          errors++;
        end else begin
          want = pending_nibbles.pop_front();
          if (out_data.nibble !== want.nibble) begin
            $error("nibble: expected %h, actual %h", want.nibble, out_data.nibble);
            errors++;
          end
          if (out_data.reg_select !== want.reg_select) begin
            $error("reg_select: expected %b, actual %b", want.reg_select,
                   out_data.reg_select);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_data.last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) decode_operation(in_data);
    end
    mismatch_count <= errors;
    nibbles_owed   <= pending_nibbles.size();
  end

endmodule

// ===== test/testbench.sv =====
// Stimulus, clock, reset and verdict for the character LCD nibble writer.
`timescale 1ns / 1ps
module testbench;
  import lcdnw_pkg::*;

  // Opcode with no operation behind it; the block must drop it
  localparam logic [2:0] OP_UNUSED    = 3'd7;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 32;
  localparam int         RANDOM_ITEMS = 120;
  localparam int         CALM_TAIL    = 30;
  localparam int         LONG_RUN     = 55;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  lcdnw_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  lcdnw_out_t out_data;

  int   mismatch_count;
  int   nibbles_owed;
  int   sent        = 0;
  int   cycle_count = 0;
  int   op_goal;
  logic send_idle   = 1'b0;
  logic recv_idle   = 1'b0;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;

  always #5 clk = ~clk;

  char_lcd_nibble_writer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lcdnw_checker watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .nibbles_owed   (nibbles_owed)
  );

  function automatic lcdnw_in_t make_op(input logic [2:0] opc, input logic [7:0] pay,
                                        input logic row, input logic [7:0] col,
                                        input logic [2:0] slot, input logic [2:0] ln);
    lcdnw_in_t it;
    it.opcode     = opc;
    it.payload    = pay;
    it.target_row = row;
    it.target_col = col;
    it.glyph_slot = slot;
    it.glyph_line = ln;
    return it;
  endfunction

  // Fill every field at random; callers overwrite what a sequence needs.
  function automatic lcdnw_in_t rand_op();
    return make_op(3'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                   3'($urandom), 3'($urandom));
  endfunction

  // Offer one beat, optionally after a random gap, and hold it until accepted.
  // The valid only drops at an accept edge, so it never falls and rises in one step.
  task automatic send_op(input lcdnw_in_t item);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Stream text characters; special_pct of them are NUL, newline or return.
  task automatic text_run(input int count, input int special_pct);
    lcdnw_in_t it;
    for (int i = 0; i < count; i++) begin
      it        = rand_op();
      it.opcode = OP_TEXT;
      if ($urandom_range(0, 99) < special_pct) begin
        case ($urandom_range(0, 2))
          0:       it.payload = CHAR_NUL;
          1:       it.payload = CHAR_LF;
          default: it.payload = CHAR_CR;
        endcase
      end
      send_op(it);
    end
  endtask

  // Pick one short, mostly well-formed burst of display traffic.
  task automatic run_sequence();
    lcdnw_in_t it;
    int        kind;
    int        first_line;
    kind = $urandom_range(0, 9);
    it   = rand_op();
    if (kind <= 3) begin
      // place the cursor on the visible line, then type
      if ($urandom_range(0, 1)) begin
        it.opcode     = OP_SETPOS;
        it.target_col = 8'($urandom_range(0, LINE_WIDTH - 1));
        send_op(it);
      end
      text_run($urandom_range(1, 20), 8);
    end else if (kind == 4) begin
      // define a glyph top to bottom; sometimes start partway down
      first_line = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
      it.opcode  = OP_GLYPH;
      for (int ln = first_line; ln < 8; ln++) begin
        it.glyph_line = 3'(ln);
        it.payload    = 8'($urandom);
        send_op(it);
      end
    end else if (kind == 5) begin
      case ($urandom_range(0, 3))
        0:       it.opcode = OP_CLEAR;
        1:       it.opcode = OP_HOME;
        2:       it.opcode = OP_RAW;
        default: it.opcode = OP_INIT;
      endcase
      send_op(it);
    end else if (kind <= 7) begin
      // raw noise: any opcode, unused one included, any field values
      send_op(it);
    end else if (kind == 8) begin
      // set position, half the time at a random column, mostly past the line end
      it.opcode = OP_SETPOS;
      if ($urandom_range(0, 1)) it.target_col = 8'($urandom_range(0, LINE_WIDTH - 1));
      send_op(it);
    end else begin
      text_run($urandom_range(2, 12), 40);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off once asked for.
  // While it holds, the sender keeps offering, so the block fills and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if it never drains.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    // hold reset at start, then release
    repeat (3) @(posedge clk);
    rst_n     <= 1'b1;
    send_idle = 1'b1;
    recv_idle <= 1'b1;

    // Directed: init first, then each operation and the cursor corner cases
    send_op(make_op(OP_INIT,   8'h00, 1'b0, 8'd0,   3'd0, 3'd0));
    send_op(make_op(OP_TEXT,   8'h41, 1'b0, 8'd0,   3'd0, 3'd0));
    send_op(make_op(OP_TEXT,   CHAR_NUL, 1'b0, 8'd0, 3'd0, 3'd0));
    send_op(make_op(OP_TEXT,   CHAR_LF,  1'b0, 8'd0, 3'd0, 3'd0));
    send_op(make_op(OP_TEXT,   CHAR_CR,  1'b0, 8'd0, 3'd0, 3'd0));
    send_op(make_op(OP_TEXT,   8'hFF, 1'b0, 8'd0,   3'd0, 3'd0));
    send_op(make_op(OP_RAW,    8'h00, 1'b0, 8'd0,   3'd0, 3'd0));
    send_op(make_op(OP_RAW,    8'hFF, 1'b0, 8'd0,   3'd0, 3'd0));
    send_op(make_op(OP_CLEAR,  8'h00, 1'b0, 8'd0,   3'd0, 3'd0));
    // last column of the bottom line; one more character runs off the end
    send_op(make_op(OP_SETPOS, 8'h00, 1'b1, 8'd15,  3'd0, 3'd0));
    send_op(make_op(OP_TEXT,   8'h7E, 1'b0, 8'd0,   3'd0, 3'd0));
    // newline and glyph restore with the column past the line send no address
    send_op(make_op(OP_TEXT,   CHAR_LF, 1'b0, 8'd0, 3'd0, 3'd0));
    send_op(make_op(OP_GLYPH,  8'hFF, 1'b0, 8'd0,   3'd7, 3'd7));
    send_op(make_op(OP_HOME,   8'h00, 1'b0, 8'd0,   3'd0, 3'd0));
    // out-of-range columns are dropped
    send_op(make_op(OP_SETPOS, 8'h00, 1'b0, 8'd16,  3'd0, 3'd0));
    send_op(make_op(OP_SETPOS, 8'hFF, 1'b1, 8'd255, 3'd7, 3'd7));
    // wrap from the top line to the bottom one
    send_op(make_op(OP_SETPOS, 8'h00, 1'b0, 8'd14,  3'd0, 3'd0));
    send_op(make_op(OP_TEXT,   8'h79, 1'b0, 8'd0,   3'd0, 3'd0));
    send_op(make_op(OP_TEXT,   8'h7A, 1'b0, 8'd0,   3'd0, 3'd0));
    send_op(make_op(OP_GLYPH,  8'h00, 1'b0, 8'd0,   3'd0, 3'd0));
    send_op(make_op(OP_GLYPH,  8'hAA, 1'b0, 8'd0,   3'd3, 3'd7));
    send_op(make_op(OP_UNUSED, 8'hFF, 1'b1, 8'hFF,  3'd7, 3'd7));
    send_op(make_op(OP_SETPOS, 8'h00, 1'b0, 8'd0,   3'd0, 3'd0));

    // Random: start the long receiver hold-off, and drive the column to saturation
    op_goal  = sent + RANDOM_ITEMS;
    hold_req <= 1'b1;
    send_op(make_op(OP_SETPOS, 8'h00, 1'b1, 8'd10, 3'd0, 3'd0));
    text_run(LONG_RUN, 0);
    while (sent < op_goal) begin
      if (sent >= op_goal - CALM_TAIL) begin
        // last stretch runs flat out on both sides
        send_idle = 1'b0;
        recv_idle <= 1'b0;
      end else begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle <= ($urandom_range(0, 3) != 0);
      end
      run_sequence();
    end

    // Drain: drop valid, wait until no nibble is owed, then let the block settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (nibbles_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && nibbles_owed == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== char_lcd_nibble_writer_top.f =====
rtl/lcdnw_pkg.sv
rtl/char_lcd_nibble_writer_top.sv
test/lcdnw_checker.sv
test/testbench.sv
